>>> design/sha256_pkg.sv
// SHA-256 stream hasher package: controller state type, command/status structs,
// initial hash values and round constant table. No dependencies.
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } ctrl_state_t;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // pad phases of a finish
    typedef enum logic [1:0] {
        PAD_NONE,
        PAD_FIRST,
        PAD_LAST
    } pad_phase_t;

    typedef struct packed {
        logic       byte_wr;      // write incoming byte into block store
        logic       pad_wr;       // write one padding byte at pad pointer
        logic       load;         // copy chaining value into working vars
        logic       round;        // run one round
        logic       fold;         // add working vars into chaining value
        logic       restart;      // reload IV, clear counters
        logic       emit_shift;   // digest word taken, rotate chain
    } dp_cmd_t;

    typedef struct packed {
        logic       block_full;   // 64 bytes pending after a byte write
        logic       rounds_done;  // last round this cycle
    } dp_stat_t;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                3'd0: v = 32'h6a09e667;
                3'd1: v = 32'hbb67ae85;
                3'd2: v = 32'h3c6ef372;
                3'd3: v = 32'ha54ff53a;
                3'd4: v = 32'h510e527f;
                3'd5: v = 32'h9b05688c;
                3'd6: v = 32'h1f83d9ab;
                default: v = 32'h5be0cd19;
            endcase
            return v;
        end
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

>>> design/sha256_if.sv
// Valid/ready channel interfaces for the SHA-256 stream hasher.
// Depends on nothing.
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

>>> design/sha256_datapath.sv
// SHA-256 datapath: block store (sixteen words, byte writes), message schedule
// window, working variables, round unit, chaining value and length counter.
// Depends on sha256_pkg.
module sha256_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha256_pkg::dp_cmd_t  cmd,
    input  logic [7:0]           data_byte,
    input  logic                 pad_sel_len,  // pad byte comes from length field
    input  logic                 pad_zero,     // pad byte is zero, else 0x80
    input  logic [5:0]           pad_ptr,
    output sha256_pkg::dp_stat_t stat,
    output logic [5:0]           fill,
    output logic [31:0]          digest_word
);
    import sha256_pkg::*;

    logic [31:0] store_mem [16];
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;
    logic [7:0]  wr_data;
    logic [5:0]  wr_addr;
    logic        wr_en;
    logic [7:0]  len_byte;
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, ep, ap, ch, mj;

    assign fill = fill_reg;
    assign digest_word = h_reg[0];

    // byte of the big-endian length for pad positions 56..63
    always_comb
    begin
        case (pad_ptr[2:0])
            3'd0: len_byte = len_reg[63:56];
            3'd1: len_byte = len_reg[55:48];
            3'd2: len_byte = len_reg[47:40];
            3'd3: len_byte = len_reg[39:32];
            3'd4: len_byte = len_reg[31:24];
            3'd5: len_byte = len_reg[23:16];
            3'd6: len_byte = len_reg[15:8];
            default: len_byte = len_reg[7:0];
        endcase
    end

    // store write port
    always_comb
    begin
        wr_en   = cmd.byte_wr | cmd.pad_wr;
        wr_addr = cmd.pad_wr ? pad_ptr : fill_reg;
        if (cmd.pad_wr)
            wr_data = pad_sel_len ? len_byte : (pad_zero ? 8'h00 : 8'h80);
        else
            wr_data = data_byte;
    end

    // byte lane of a big-endian word, lowest address in the top byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (wr_addr[1:0])
                2'd0: store_mem[wr_addr[5:2]][31:24] <= wr_data;
                2'd1: store_mem[wr_addr[5:2]][23:16] <= wr_data;
                2'd2: store_mem[wr_addr[5:2]][15:8]  <= wr_data;
                default: store_mem[wr_addr[5:2]][7:0] <= wr_data;
            endcase
        end
    end

    // fill count and length
    always_comb
    begin
        fill_next = fill_reg;
        len_next  = len_reg;
        if (cmd.restart)
        begin
            fill_next = '0;
            len_next  = '0;
        end
        else if (cmd.byte_wr)
        begin
            fill_next = fill_reg + 6'd1;
            len_next  = len_reg + 64'd8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            len_reg  <= len_next;
        end
    end

    assign stat.block_full  = cmd.byte_wr && (fill_reg == 6'd63);
    assign stat.rounds_done = cmd.round && (rnd_reg == 6'd63);

    // schedule word: first 16 rounds read the store, later ones extend
    assign s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
              ^ (w_reg[1] >> 3);
    assign s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
              ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];
    assign w_cur = (rnd_reg < 6'd16) ? store_mem[rnd_reg[3:0]] : w_new;

    // round function
    assign ep = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
              ^ {v_reg[4][24:0], v_reg[4][31:25]};
    assign ap = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
              ^ {v_reg[0][21:0], v_reg[0][31:22]};
    assign ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1 = v_reg[7] + ep + ch + ROUND_K[rnd_reg] + w_cur;
    assign t2 = ap + mj;

    // working variables, window, round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_reg <= '0;
        else if (cmd.load)
            rnd_reg <= '0;
        else if (cmd.round)
            rnd_reg <= rnd_reg + 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.round)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_cur;
        end
    end

    // chaining value: fold, rotate on emit, reload on restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(3'(i));
        end
        else if (cmd.restart)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(3'(i));
        end
        else if (cmd.fold)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end
        else if (cmd.emit_shift)
        begin
            for (int i = 0; i < 7; i++)
                h_reg[i] <= h_reg[i + 1];
            h_reg[7] <= h_reg[0];
        end
    end

endmodule

>>> design/sha256_ctrl.sv
// SHA-256 controller: accepts items, sequences padding, rounds and digest
// output. Depends on sha256_pkg.
module sha256_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_operation,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           word_index,
    output logic                 last_word,
    input  logic [5:0]           fill,
    input  sha256_pkg::dp_stat_t stat,
    output sha256_pkg::dp_cmd_t  cmd,
    output logic                 pad_sel_len,
    output logic                 pad_zero,
    output logic [5:0]           pad_ptr
);
    import sha256_pkg::*;

    ctrl_state_t state_reg, state_next;
    pad_phase_t  phase_reg, phase_next;
    logic [5:0]  ptr_reg, ptr_next;
    logic [2:0]  idx_reg, idx_next;
    logic        in_xfer, out_xfer, pad_end;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_EMIT);
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 3'd7);
    assign pad_ptr    = ptr_reg;
    assign in_xfer    = in_valid && in_ready;
    assign out_xfer   = out_valid && out_ready;
    // marker byte at first pad position, length bytes 56..63 on the final block;
    // on a second pad block the fill is above 55, so no position below 56 matches it
    assign pad_zero    = (ptr_reg != fill);
    assign pad_sel_len = (phase_reg == PAD_LAST) && ptr_reg[5:3] == 3'd7;
    assign pad_end     = (ptr_reg == 6'd63);

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && in_operation == OP_FINISH)
                begin
                    state_next = ST_LOAD;
                    ptr_next   = fill;
                    phase_next = (fill > 6'd55) ? PAD_FIRST : PAD_LAST;
                end
                else if (in_xfer && stat.block_full)
                begin
                    state_next = ST_ROUND;
                    phase_next = PAD_NONE;
                end
            end
            ST_LOAD:
            begin
                // pad loop: one byte per cycle until position 63
                if (pad_end)
                    state_next = ST_ROUND;
                else
                    ptr_next = ptr_reg + 6'd1;
            end
            ST_ROUND:
                if (stat.rounds_done)
                    state_next = ST_FOLD;
            ST_FOLD:
            begin
                unique case (phase_reg)
                    PAD_NONE:  state_next = ST_IDLE;
                    PAD_FIRST:
                    begin
                        state_next = ST_LOAD;
                        phase_next = PAD_LAST;
                        ptr_next   = '0;
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                        idx_next   = '0;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.byte_wr = in_xfer && in_operation == OP_ABSORB;
                cmd.load    = in_xfer;
            end
            ST_LOAD:
            begin
                cmd.pad_wr = 1'b1;
                cmd.load   = 1'b1;
            end
            ST_ROUND: cmd.round = 1'b1;
            ST_FOLD:  cmd.fold  = 1'b1;
            ST_EMIT:
            begin
                cmd.emit_shift = out_xfer;
                cmd.restart    = out_xfer && last_word;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PAD_NONE;
            ptr_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ptr_reg   <= ptr_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

>>> design/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher top level: controller plus datapath.
// Depends on sha256_pkg, sha256_if, sha256_ctrl, sha256_datapath.
//
//  channel | dir | transfer payload
//  in_ch   | in  | operation, data_byte
//  out_ch  | out | digest_word, word_index, last_word
//
// Absorb bytes are taken while idle; the 64th byte of a block starts 64 rounds
// and a fold, and no new byte is accepted until they are done.
// A finish pads one byte per cycle up to position 63, then 64 rounds and a fold
// per block (two blocks past 55 pending bytes), then eight digest transfers.
// Reset loads the initial hash values; output stalls hold the controller.
module sha256_stream_hasher_unit (
    input logic        clk,
    input logic        rst_n,
    sha256_in_if.sink  in_ch,
    sha256_out_if.source out_ch
);
    import sha256_pkg::*;

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [5:0] fill, pad_ptr;
    logic       pad_sel_len, pad_zero;

    sha256_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_operation (in_ch.operation),
        .in_ready     (in_ch.ready),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .word_index   (out_ch.word_index),
        .last_word    (out_ch.last_word),
        .fill         (fill),
        .stat         (stat),
        .cmd          (cmd),
        .pad_sel_len  (pad_sel_len),
        .pad_zero     (pad_zero),
        .pad_ptr      (pad_ptr)
    );

    sha256_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (in_ch.data_byte),
        .pad_sel_len (pad_sel_len),
        .pad_zero    (pad_zero),
        .pad_ptr     (pad_ptr),
        .stat        (stat),
        .fill        (fill),
        .digest_word (out_ch.digest_word)
    );

endmodule

>>> sim/sha256_stream_hasher_unit_tb.sv
// Self-checking testbench for the SHA-256 stream hasher: drives message bytes and
// finish commands, predicts each digest in SystemVerilog and checks every word.
// Depends on sha256_pkg, sha256_if and sha256_stream_hasher_unit.
module sha256_stream_hasher_unit_tb;
    import sha256_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_out_t;

    typedef struct {
        logic        operation;
        logic [7:0]  data_byte;
        logic        typed;       // expected first digest word given in the table
        logic [31:0] first_word;
    } msg_row_t;

    logic clk;
    logic rst_n;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_stream_hasher_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned pending_bytes;
    logic [63:0] msg_bits;

    digest_out_t digest_q [$];
    int unsigned mismatches;
    int unsigned idle_cycles;
    logic        timed_out;
    logic        stim_done;

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of msg_block into hash_state
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        for (int t = 16; t < 64; t++)
        begin
            w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        end
        for (int t = 0; t < 8; t++)
        begin
            v[t] = hash_state[t];
        end
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++)
        begin
            hash_state[t] = hash_state[t] + v[t];
        end
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = init_hash(3'(i));
        end
        pending_bytes = 0;
        msg_bits = '0;
    endtask

    // advance the predictor by one accepted transfer; queue digest words on finish
    task automatic predict_digest(input logic op, input logic [7:0] b);
        digest_out_t d;
        if (op == OP_ABSORB)
        begin
            msg_block[pending_bytes] = b;
            pending_bytes++;
            msg_bits = msg_bits + 64'd8;
            if (pending_bytes == 64)
            begin
                compress_block();
                pending_bytes = 0;
            end
        end
        else
        begin
            msg_block[pending_bytes] = 8'h80;
            for (int i = pending_bytes + 1; i < 64; i++)
            begin
                msg_block[i] = 8'h00;
            end
            // no room for the length field: extra block
            if (pending_bytes + 1 > 56)
            begin
                compress_block();
                for (int i = 0; i < 64; i++)
                begin
                    msg_block[i] = 8'h00;
                end
            end
            for (int i = 0; i < 8; i++)
            begin
                msg_block[56+i] = msg_bits[63-8*i -: 8];
            end
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = hash_state[i];
                d.word_index  = 3'(i);
                d.last_word   = (i == 7);
                digest_q.push_back(d);
            end
            restart_hash();
        end
    endtask

    // send one transfer after a random gap, inputs change on the falling edge
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        predict_digest(op, b);
        @(negedge clk);
    endtask

    // sink side: random stalls, compare each transfer with the oldest expectation
    initial
    begin
        int stall;
        digest_out_t exp_w;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
            begin
                @(posedge clk);
            end
            if (digest_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected digest word %h index %0d",
                             out_ch.digest_word, out_ch.word_index);
                end
            end
            else
            begin
                exp_w = digest_q.pop_front();
                if (out_ch.digest_word !== exp_w.digest_word
                    || out_ch.word_index !== exp_w.word_index
                    || out_ch.last_word !== exp_w.last_word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                                 out_ch.digest_word, out_ch.word_index,
                                 out_ch.last_word);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (rst_n && !stim_done)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                timed_out = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (timed_out)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        msg_row_t dir_rows [$];
        int pad_lens [3];
        int n_items;
        int len;
        logic [31:0] first_exp;
        logic [7:0] rb;

        mismatches  = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        stim_done   = 1'b0;
        rst_n       = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_ABSORB;
        in_ch.data_byte = 8'h00;
        for (int i = 0; i < 64; i++)
        begin
            msg_block[i] = 8'h00;
        end
        restart_hash();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: empty message (with ignored byte), "abc", and bytes ff, 00, 55, aa
        dir_rows = '{
            '{OP_FINISH, 8'hff, 1'b1, 32'he3b0c442},
            '{OP_ABSORB, 8'h61, 1'b0, 32'h0},
            '{OP_ABSORB, 8'h62, 1'b0, 32'h0},
            '{OP_ABSORB, 8'h63, 1'b0, 32'h0},
            '{OP_FINISH, 8'h00, 1'b1, 32'hba7816bf},
            '{OP_ABSORB, 8'hff, 1'b0, 32'h0},
            '{OP_ABSORB, 8'h00, 1'b0, 32'h0},
            '{OP_ABSORB, 8'h55, 1'b0, 32'h0},
            '{OP_ABSORB, 8'haa, 1'b0, 32'h0},
            '{OP_FINISH, 8'h00, 1'b0, 32'h0}
        };
        foreach (dir_rows[r])
        begin
            send_item(dir_rows[r].operation, dir_rows[r].data_byte);
            // the table value must agree with the predictor
            if (dir_rows[r].typed && digest_q.size() >= 8)
            begin
                first_exp = digest_q[digest_q.size() - 8].digest_word;
                if (first_exp !== dir_rows[r].first_word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("table digest: exp %h predicted %h",
                                 dir_rows[r].first_word, first_exp);
                    end
                end
            end
        end

        // padding boundaries: 55, 56 and 64 bytes
        pad_lens = '{55, 56, 64};
        foreach (pad_lens[k])
        begin
            len = pad_lens[k];
            for (int i = 0; i < len; i++)
            begin
                send_item(OP_ABSORB, 8'($urandom));
            end
            send_item(OP_FINISH, 8'($urandom));
        end

        // random messages, mostly short, some across block boundaries
        n_items = 0;
        while (n_items < 110)
        begin
            len = $urandom_range(0, 7) == 0 ? $urandom_range(50, 72) : $urandom_range(0, 20);
            for (int i = 0; i < len; i++)
            begin
                rb = 8'($urandom);
                send_item(OP_ABSORB, rb);
                n_items++;
            end
            send_item(OP_FINISH, 8'($urandom));
            n_items++;
        end
        in_ch.valid <= 1'b0;

        // drain
        while (digest_q.size() != 0)
        begin
            @(posedge clk);
        end
        stim_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && digest_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/sha256_pkg.sv
design/sha256_if.sv
design/sha256_datapath.sv
design/sha256_ctrl.sv
design/sha256_stream_hasher_unit.sv
sim/sha256_stream_hasher_unit_tb.sv
